### hw/rtl/ucss_pkg.sv
package ucss_pkg;

  // unwind operation codes, bits 11:8 of a slot word
  localparam logic [3:0] OP_PUSH_NONVOL = 4'd0;
  localparam logic [3:0] OP_ALLOC_LARGE = 4'd1;
  localparam logic [3:0] OP_ALLOC_SMALL = 4'd2;
  localparam logic [3:0] OP_SAVE_NONVOL = 4'd4;

  // item kinds
  localparam logic REQ_SLOT      = 1'b0;
  localparam logic REQ_BLOCK_END = 1'b1;

  // return address size added on a final block end
  localparam logic [31:0] RET_ADDR_BYTES = 32'd8;
  localparam logic [31:0] PUSH_BYTES     = 32'd8;

  // pending large alloc
  typedef enum logic [1:0] {
    LM_NONE   = 2'd0,
    LM_SCALED = 2'd1,
    LM_LOW    = 2'd2,
    LM_HIGH   = 2'd3
  } lm_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] code_slot;
    logic        chained;
  } ucss_in_t;

  typedef struct packed {
    logic [31:0] stack_size;
    logic        truncated;
  } ucss_out_t;

endpackage

### hw/rtl/unwind_code_stack_size.sv
// x64 unwind info stack frame size: takes one 16-bit unwind code slot or one
// block-end marker per transfer on the slot channel and adds up the stack
// space the prologue allocates (push 8, small alloc info*8+8, large alloc
// from the following one or two slots, save-nonvol skips its extra slot).
// a block end with chained clear delivers one transfer on the size channel:
// the total plus 8 for the return address, modulo 2^32, and a flag set if
// any block of the function ended while extra slots were still expected;
// a chained block end carries the total on into the next block. slot
// transfers and chained block ends produce nothing. one item is taken every
// cycle unless the slot channel stalls; the rate is set by the single 32-bit
// add that updates the running total. a block end is held in the input
// register and its result in the result register, and the slot channel only
// stalls when a final block end is waiting behind a result not yet taken.
module unwind_code_stack_size (
  input  logic               clk,
  input  logic               rst,
  input  logic               slot_valid,
  output logic               slot_ready,
  input  ucss_pkg::ucss_in_t slot,
  output logic               size_valid,
  input  logic               size_ready,
  output ucss_pkg::ucss_out_t size
);
  import ucss_pkg::*;

  // input register
  ucss_in_t  item;
  logic      item_full;

  // result register
  ucss_out_t size_q;
  logic      size_full;

  logic      emit;
  logic      step;
  ucss_out_t result;

  // the held item may only update state if its result has somewhere to go
  assign step = item_full && (!emit || !size_full || size_ready);
  assign slot_ready = !item_full || step;

  ucss_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .emit   (emit),
    .result (result)
  );

  // input stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (slot_ready) begin
      item_full <= slot_valid;
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk) begin
    if (slot_valid && slot_ready) begin
      item <= slot;
    end
  end

  // result stage: refilled in the same cycle it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      size_full <= 1'b0;
    end else if (step && emit) begin
      size_full <= 1'b1;
    end else if (size_ready) begin
      size_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      size_q <= result;
    end
  end

  assign size_valid = size_full;
  assign size       = size_q;

endmodule

### hw/rtl/ucss_accum.sv
module ucss_accum (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  ucss_pkg::ucss_in_t item,
  output logic              emit,
  output ucss_pkg::ucss_out_t result
);
  import ucss_pkg::*;

  logic [31:0] running_total, running_total_next;
  logic        skip_pending, skip_pending_next;
  lm_t         large_mode, large_mode_next;
  logic [15:0] partial_offset, partial_offset_next;
  logic        truncated_seen, truncated_seen_next;

  logic [3:0]  op;
  logic [3:0]  info;
  logic [31:0] addend;
  logic        ending;
  logic        dropped;

  assign op      = item.code_slot[11:8];
  assign info    = item.code_slot[15:12];
  assign ending  = step && (item.req_type == REQ_BLOCK_END);
  assign dropped = skip_pending || (large_mode != LM_NONE);

  // large alloc tracking
  always_comb begin
    large_mode_next = large_mode;
    if (step) begin
      if (item.req_type == REQ_BLOCK_END) begin
        large_mode_next = LM_NONE;
      end else begin
        case (large_mode)
          LM_SCALED: large_mode_next = LM_NONE;
          LM_LOW:    large_mode_next = LM_HIGH;
          LM_HIGH:   large_mode_next = LM_NONE;
          LM_NONE: begin
            if (!skip_pending && op == OP_ALLOC_LARGE) begin
              large_mode_next = (info == 4'd0) ? LM_SCALED : LM_LOW;
            end
          end
          default:   large_mode_next = LM_NONE;
        endcase
      end
    end
  end

  // accumulator datapath
  always_comb begin
    addend              = '0;
    skip_pending_next   = skip_pending;
    partial_offset_next = partial_offset;
    truncated_seen_next = truncated_seen;
    if (step && item.req_type == REQ_SLOT) begin
      case (large_mode)
        LM_SCALED: addend = {13'd0, item.code_slot, 3'd0};
        LM_LOW:    partial_offset_next = item.code_slot;
        LM_HIGH: begin
          addend              = {item.code_slot, partial_offset};
          partial_offset_next = '0;
        end
        LM_NONE: begin
          if (skip_pending) begin
            skip_pending_next = 1'b0;
          end else begin
            case (op)
              OP_PUSH_NONVOL: addend = PUSH_BYTES;
              OP_ALLOC_SMALL: addend = {24'd0, ({1'b0, info} + 5'd1), 3'd0};
              OP_SAVE_NONVOL: skip_pending_next = 1'b1;
              default:        addend = '0;
            endcase
          end
        end
        default: addend = '0;
      endcase
    end
    running_total_next = running_total + addend;
    if (ending) begin
      skip_pending_next   = 1'b0;
      partial_offset_next = '0;
      if (dropped) begin
        truncated_seen_next = 1'b1;
      end
      if (!item.chained) begin
        running_total_next  = '0;
        truncated_seen_next = 1'b0;
      end
    end
  end

  // the held item would produce a result, independent of whether it steps
  assign emit              = (item.req_type == REQ_BLOCK_END) && !item.chained;
  assign result.stack_size = running_total + RET_ADDR_BYTES;
  assign result.truncated  = truncated_seen || dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_total  <= '0;
      skip_pending   <= 1'b0;
      large_mode     <= LM_NONE;
      partial_offset <= '0;
      truncated_seen <= 1'b0;
    end else begin
      running_total  <= running_total_next;
      skip_pending   <= skip_pending_next;
      large_mode     <= large_mode_next;
      partial_offset <= partial_offset_next;
      truncated_seen <= truncated_seen_next;
    end
  end

endmodule

### hw/rtl/ucss_checker.sv
module ucss_checker (
  input logic                clk,
  input logic                rst,
  input logic                slot_valid,
  input logic                slot_ready,
  input ucss_pkg::ucss_in_t  slot,
  input logic                size_valid,
  input logic                size_ready,
  input ucss_pkg::ucss_out_t size
);
  import ucss_pkg::*;

  logic final_transfer;

  assign final_transfer = slot_valid && slot_ready &&
                          (slot.req_type == REQ_BLOCK_END) && !slot.chained;

  // both sides come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !size_valid && slot_ready)
    else $error("not empty after reset");

  // input only stalls behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !slot_ready |-> size_valid && !size_ready)
    else $error("slot channel stalled without a blocked result");

  // a new result follows a final block end transfer
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(size_valid) |-> $past(final_transfer, 2))
    else $error("result without a final block end");

  // a waiting result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    size_valid && !size_ready |=> size_valid && $stable(size))
    else $error("result dropped or changed while stalled");

endmodule

bind unwind_code_stack_size ucss_checker u_ucss_checker (.*);

### verif/tb_unwind_code_stack_size.sv
module tb_unwind_code_stack_size;
  timeunit 1ns;
  timeprecision 1ps;

  import ucss_pkg::*;

  // random slot transfers after the directed table
  localparam int RANDOM_ITEMS = 1550;

  // one row of the directed table: the transfer and, where it is plain to
  // see, the frame size it must produce
  typedef struct {
    ucss_in_t  item;
    bit        typed;
    ucss_out_t want;
  } plan_row_t;

  logic      clk;
  logic      rst;
  logic      slot_valid;
  logic      slot_ready;
  ucss_in_t  slot;
  logic      size_valid;
  logic      size_ready;
  ucss_out_t size;

  unwind_code_stack_size i_dut (
    .clk        (clk),
    .rst        (rst),
    .slot_valid (slot_valid),
    .slot_ready (slot_ready),
    .slot       (slot),
    .size_valid (size_valid),
    .size_ready (size_ready),
    .size       (size)
  );

  always #1 clk = ~clk;

  // predicted frame state, kept in step with every accepted slot transfer
  logic [31:0] frame_bytes;
  logic [1:0]  skip_left;
  lm_t         large_wait;
  logic [15:0] low_half;
  logic        trunc_sticky;

  // frame sizes still owed by the block, oldest first
  ucss_out_t size_due[$];
  // transfers waiting to be sent for the current random function
  ucss_in_t  slot_plan[$];

  int  mismatches;
  int  items_sent;
  int  chained_ends;
  int  sizes_checked;
  int  sizes_flagged;
  int  stall_left;
  // when set, neither side idles
  bit  steady;

  // mostly back to back, often a short pause, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic ucss_in_t make_item(logic kind, logic [15:0] word, logic chain);
    ucss_in_t it;
    it.req_type  = kind;
    it.code_slot = word;
    it.chained   = chain;
    return it;
  endfunction

  function automatic plan_row_t plan_row(logic kind, logic [15:0] word, logic chain,
                                         bit typed, logic [31:0] bytes, logic trunc);
    plan_row_t r;
    r.item            = make_item(kind, word, chain);
    r.typed           = typed;
    r.want.stack_size = bytes;
    r.want.truncated  = trunc;
    return r;
  endfunction

  function automatic void clear_frame();
    frame_bytes  = '0;
    skip_left    = '0;
    large_wait   = LM_NONE;
    low_half     = '0;
    trunc_sticky = 1'b0;
  endfunction

  // frame size predictor: folds one transfer into the running frame and
  // hands back the size owed when a function closes
  task automatic track_frame(input ucss_in_t it, output bit emits, output ucss_out_t res);
    logic [3:0] op;
    logic [3:0] info;
    op    = it.code_slot[11:8];
    info  = it.code_slot[15:12];
    emits = 1'b0;
    res   = '0;
    if (it.req_type == REQ_SLOT) begin
      case (large_wait)
        // large alloc, one slot scaled by 8
        LM_SCALED: begin
          frame_bytes += {13'd0, it.code_slot, 3'd0};
          large_wait  = LM_NONE;
        end
        // large alloc, low half of the 32-bit size
        LM_LOW: begin
          low_half   = it.code_slot;
          large_wait = LM_HIGH;
        end
        // large alloc, high half completes the size
        LM_HIGH: begin
          frame_bytes += {it.code_slot, low_half};
          low_half    = '0;
          large_wait  = LM_NONE;
        end
        default: begin
          if (skip_left != 2'd0) begin
            skip_left--;
          end else if (op == OP_PUSH_NONVOL) begin
            frame_bytes += PUSH_BYTES;
          end else if (op == OP_ALLOC_SMALL) begin
            frame_bytes += {25'd0, info, 3'd0} + PUSH_BYTES;
          end else if (op == OP_ALLOC_LARGE) begin
            large_wait = (info == 4'd0) ? LM_SCALED : LM_LOW;
          end else if (op == OP_SAVE_NONVOL) begin
            skip_left = 2'd1;
          end
        end
      endcase
    end else begin
      // a block closing with extra slots outstanding drops them
      if (skip_left != 2'd0 || large_wait != LM_NONE) begin
        trunc_sticky = 1'b1;
        skip_left    = '0;
        large_wait   = LM_NONE;
        low_half     = '0;
      end
      if (!it.chained) begin
        emits          = 1'b1;
        res.stack_size = frame_bytes + RET_ADDR_BYTES;
        res.truncated  = trunc_sticky;
        clear_frame();
      end
    end
  endtask

  // one slot transfer, with an optional idle gap before it
  task automatic feed_slot(input ucss_in_t it, input bit typed, input ucss_out_t want);
    int        gap;
    bit        emits;
    ucss_out_t res;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      slot_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    slot_valid <= 1'b1;
    slot       <= it;
    do @(posedge clk); while (!slot_ready);
    track_frame(it, emits, res);
    if (typed) size_due.push_back(want);
    else if (emits) size_due.push_back(res);
    items_sent++;
    if (it.req_type == REQ_BLOCK_END && it.chained) chained_ends++;
  endtask

  function automatic void note_mismatch(string what, ucss_out_t want, ucss_out_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected size %h trunc %0b, got size %h trunc %0b",
               $realtime, what, want.stack_size, want.truncated,
               got.stack_size, got.truncated);
  endfunction

  // one well-formed function: a few blocks of unwind codes, now and then a
  // block cut short with extra slots still owed
  task automatic build_function();
    int         blocks;
    int         codes;
    int         pick;
    logic [3:0] op;
    blocks = $urandom_range(1, 3);
    for (int b = 0; b < blocks; b++) begin
      codes = $urandom_range(0, 8);
      for (int c = 0; c < codes; c++) begin
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
          slot_plan.push_back(make_item(REQ_SLOT,
            {4'($urandom), OP_PUSH_NONVOL, 8'($urandom)}, 1'($urandom)));
        end else if (pick < 5) begin
          slot_plan.push_back(make_item(REQ_SLOT,
            {4'($urandom), OP_ALLOC_SMALL, 8'($urandom)}, 1'($urandom)));
        end else if (pick == 5) begin
          slot_plan.push_back(make_item(REQ_SLOT,
            {4'd0, OP_ALLOC_LARGE, 8'($urandom)}, 1'($urandom)));
          slot_plan.push_back(make_item(REQ_SLOT, 16'($urandom), 1'($urandom)));
        end else if (pick == 6) begin
          slot_plan.push_back(make_item(REQ_SLOT,
            {4'($urandom_range(1, 15)), OP_ALLOC_LARGE, 8'($urandom)}, 1'($urandom)));
          slot_plan.push_back(make_item(REQ_SLOT, 16'($urandom), 1'($urandom)));
          slot_plan.push_back(make_item(REQ_SLOT, 16'($urandom), 1'($urandom)));
        end else if (pick == 7) begin
          slot_plan.push_back(make_item(REQ_SLOT,
            {4'($urandom), OP_SAVE_NONVOL, 8'($urandom)}, 1'($urandom)));
          slot_plan.push_back(make_item(REQ_SLOT, 16'($urandom), 1'($urandom)));
        end else begin
          // codes that add nothing
          op = 4'($urandom_range(3, 15));
          if (op == OP_SAVE_NONVOL) op = 4'd5;
          slot_plan.push_back(make_item(REQ_SLOT,
            {4'($urandom), op, 8'($urandom)}, 1'($urandom)));
        end
      end
      // block cut short: the opener arrives but not all of its extra slots
      if ($urandom_range(0, 11) == 0) begin
        case ($urandom_range(0, 3))
          0: slot_plan.push_back(make_item(REQ_SLOT,
               {4'($urandom), OP_SAVE_NONVOL, 8'($urandom)}, 1'b0));
          1: slot_plan.push_back(make_item(REQ_SLOT,
               {4'd0, OP_ALLOC_LARGE, 8'($urandom)}, 1'b0));
          2: slot_plan.push_back(make_item(REQ_SLOT,
               {4'($urandom_range(1, 15)), OP_ALLOC_LARGE, 8'($urandom)}, 1'b0));
          default: begin
            slot_plan.push_back(make_item(REQ_SLOT,
              {4'($urandom_range(1, 15)), OP_ALLOC_LARGE, 8'($urandom)}, 1'b0));
            slot_plan.push_back(make_item(REQ_SLOT, 16'($urandom), 1'b0));
          end
        endcase
      end
      slot_plan.push_back(make_item(REQ_BLOCK_END, 16'($urandom), b != blocks - 1));
    end
  endtask

  // size channel: check every transfer against the oldest owed size, then
  // pace ready with random stalls
  always @(posedge clk) begin : size_sink
    ucss_out_t want;
    if (!rst && size_valid && size_ready) begin
      if (size_due.size() == 0) begin
        note_mismatch("frame size with none owed", '0, size);
      end else begin
        want = size_due.pop_front();
        sizes_checked++;
        if (want.truncated) sizes_flagged++;
        if (size.stack_size !== want.stack_size || size.truncated !== want.truncated)
          note_mismatch("frame size mismatch", want, size);
      end
    end
    if (stall_left != 0) begin
      size_ready <= 1'b0;
      stall_left--;
    end else if (!steady && $urandom_range(0, 4) == 0) begin
      size_ready <= 1'b0;
      stall_left = pick_gap();
    end else begin
      size_ready <= 1'b1;
    end
  end

  // watchdog
  initial begin
    #1_500_000;
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    plan_row_t plan[$];
    ucss_in_t  it;
    int        random_sent;
    int        fn_count;

    clk           = 1'b0;
    rst           = 1'b1;
    slot_valid    = 1'b0;
    slot          = '0;
    size_ready    = 1'b0;
    stall_left    = 0;
    steady        = 1'b0;
    mismatches    = 0;
    items_sent    = 0;
    chained_ends  = 0;
    sizes_checked = 0;
    sizes_flagged = 0;
    random_sent   = 0;
    fn_count      = 0;
    clear_frame();

    // directed table
    // empty function straight after reset: only the return address
    plan.push_back(plan_row(REQ_BLOCK_END, 16'h0000, 1'b0, 1, 32'd8, 1'b0));
    // push with info and low byte set, chained set on a slot is ignored
    plan.push_back(plan_row(REQ_SLOT, 16'hF0FF, 1'b1, 0, '0, 1'b0));
    // small alloc, largest and smallest info
    plan.push_back(plan_row(REQ_SLOT, 16'hF200, 1'b0, 0, '0, 1'b0));
    plan.push_back(plan_row(REQ_SLOT, 16'h0200, 1'b0, 0, '0, 1'b0));
    // save-nonvol skips what would otherwise be a small alloc
    plan.push_back(plan_row(REQ_SLOT, 16'h0400, 1'b0, 0, '0, 1'b0));
    plan.push_back(plan_row(REQ_SLOT, 16'h0200, 1'b0, 0, '0, 1'b0));
    // large alloc, scaled slot at its top value
    plan.push_back(plan_row(REQ_SLOT, 16'h0100, 1'b0, 0, '0, 1'b0));
    plan.push_back(plan_row(REQ_SLOT, 16'hFFFF, 1'b0, 0, '0, 1'b0));
    // codes that add nothing
    plan.push_back(plan_row(REQ_SLOT, 16'h3300, 1'b0, 0, '0, 1'b0));
    plan.push_back(plan_row(REQ_SLOT, 16'hFFFF, 1'b0, 0, '0, 1'b0));
    // chained block end, its slot word ignored; total carries over
    plan.push_back(plan_row(REQ_BLOCK_END, 16'hFFFF, 1'b1, 0, '0, 1'b0));
    plan.push_back(plan_row(REQ_SLOT, 16'h0000, 1'b0, 0, '0, 1'b0));
    plan.push_back(plan_row(REQ_BLOCK_END, 16'h5A5A, 1'b0, 0, '0, 1'b0));
    // two-slot large alloc of all ones, return address wraps the sum
    plan.push_back(plan_row(REQ_SLOT, 16'hF100, 1'b0, 0, '0, 1'b0));
    plan.push_back(plan_row(REQ_SLOT, 16'hFFFF, 1'b0, 0, '0, 1'b0));
    plan.push_back(plan_row(REQ_SLOT, 16'hFFFF, 1'b0, 0, '0, 1'b0));
    plan.push_back(plan_row(REQ_BLOCK_END, 16'h0000, 1'b0, 1, 32'h0000_0007, 1'b0));
    // block ends while a save-nonvol slot is owed
    plan.push_back(plan_row(REQ_SLOT, 16'h0400, 1'b0, 0, '0, 1'b0));
    plan.push_back(plan_row(REQ_BLOCK_END, 16'h0000, 1'b0, 1, 32'd8, 1'b1));
    // truncation in a chained block sticks to the whole function
    plan.push_back(plan_row(REQ_SLOT, 16'h0100, 1'b0, 0, '0, 1'b0));
    plan.push_back(plan_row(REQ_BLOCK_END, 16'h0000, 1'b1, 0, '0, 1'b0));
    plan.push_back(plan_row(REQ_SLOT, 16'h0000, 1'b0, 0, '0, 1'b0));
    plan.push_back(plan_row(REQ_BLOCK_END, 16'h0000, 1'b0, 1, 32'd16, 1'b1));
    // block ends with only the low half of a two-slot alloc in
    plan.push_back(plan_row(REQ_SLOT, 16'h1100, 1'b0, 0, '0, 1'b0));
    plan.push_back(plan_row(REQ_SLOT, 16'h1234, 1'b0, 0, '0, 1'b0));
    plan.push_back(plan_row(REQ_BLOCK_END, 16'h0000, 1'b0, 1, 32'd8, 1'b1));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) feed_slot(plan[i].item, plan[i].typed, plan[i].want);

    // random part: mostly whole functions, some raw noise
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 5))
          slot_plan.push_back(make_item(1'($urandom), 16'($urandom), 1'($urandom)));
      end else begin
        build_function();
      end
      while (slot_plan.size() != 0) begin
        it = slot_plan.pop_front();
        feed_slot(it, 0, '0);
        random_sent++;
      end
      fn_count++;
      // hold the sender off until every owed size has been taken
      if (fn_count == 40 || $urandom_range(0, 59) == 0) begin
        slot_valid <= 1'b0;
        @(posedge clk);
        while (size_due.size() != 0) @(posedge clk);
      end
      // switch between idling and flat-out stretches
      if ($urandom_range(0, 24) == 0) steady = !steady;
    end

    slot_valid <= 1'b0;
    for (int n = 0; n < 20000 && size_due.size() != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (size_due.size() != 0) begin
      mismatches += size_due.size();
      $display("%0d frame sizes never arrived", size_due.size());
    end

    $display("run covered %0d slot transfers with %0d chained block ends", items_sent,
             chained_ends);
    $display("%0d frame sizes checked, %0d of them flagged as truncated", sizes_checked,
             sizes_flagged);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
